[rtl/sspq_pkg.sv]
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared types and constants for the stable sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sspq_pkg;

  // Fixed field widths of the request and response channels
  localparam int PRI_W = 4;
  localparam int TAG_W = 32;
  localparam int OCC_W = 5;

  typedef enum logic [0:0] {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [PRI_W-1:0] pri;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/sspq_if.sv]
// ----------------------------------------------------------------------------
// sspq_if
// Request and response channels of the stable sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface sspq_req_if import sspq_pkg::*; ();
  logic             valid;
  logic             ready;
  kind_e            kind;
  logic [PRI_W-1:0] priority_req;
  logic [TAG_W-1:0] tag;

  modport source (output valid, kind, priority_req, tag, input ready);
  modport sink   (input valid, kind, priority_req, tag, output ready);
endinterface

interface sspq_rsp_if import sspq_pkg::*; ();
  logic             valid;
  logic             ready;
  status_e          status;
  logic             out_valid;
  logic [PRI_W-1:0] out_priority;
  logic [TAG_W-1:0] out_tag;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, status, out_valid, out_priority, out_tag, occupancy,
                  input ready);
  modport sink   (input valid, status, out_valid, out_priority, out_tag, occupancy,
                  output ready);
endinterface

`default_nettype wire

[rtl/stable_sorted_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_unit
// Bounded priority queue kept sorted in a shifting row of cells.
// ----------------------------------------------------------------------------
// Each request is an insert or a remove and yields one response in the cycle
// after it is accepted. The row of DEPTH compare cells moves every entry at
// once, so a new request is accepted each cycle while the response register
// is empty or being drained. Inserts go behind every stored entry of equal or
// lower priority number (ties leave in arrival order); priorities of
// PRIORITY_LEVELS or more saturate to the top level. A remove on an empty
// queue reports empty, an insert on a full queue reports full, and neither
// changes the contents. Occupancy shows the low five bits of the entry count
// after the request.
`default_nettype none

module stable_sorted_priority_queue_unit import sspq_pkg::*; #(
  parameter int DEPTH           = 16,
  parameter int PRIORITY_LEVELS = 16,
  parameter int TAG_BITS        = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sspq_req_if.sink   req_i,
  sspq_rsp_if.source rsp_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                fire, full, empty, do_ins, do_rem;
  logic [PRI_W-1:0]    pri_sat;
  logic [TAG_BITS-1:0] tag_in;
  logic [CNT_W-1:0]    count_q, count_d;
  cmd_t                cmd;

  // Row links: cell i owns index i+1, its neighbors sit at i and i+2
  logic                keep_a [0:DEPTH];
  logic [PRI_W-1:0]    pri_a  [0:DEPTH+1];
  logic [TAG_BITS-1:0] tag_a  [0:DEPTH+1];

  logic                rsp_vld_q;
  status_e             status_q, status_d;
  logic                outv_q;
  logic [PRI_W-1:0]    opri_q, opri_d;
  logic [TAG_W-1:0]    otag_q, otag_d;
  logic [OCC_W-1:0]    occ_q;

  assign req_i.ready = !rsp_vld_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;
  assign full        = count_q == CNT_W'(DEPTH);
  assign empty       = count_q == '0;
  assign do_ins      = fire && (req_i.kind == KIND_INSERT) && !full;
  assign do_rem      = fire && (req_i.kind == KIND_REMOVE) && !empty;

  always_comb begin
    if (32'(req_i.priority_req) >= PRIORITY_LEVELS) begin
      pri_sat = PRI_W'(PRIORITY_LEVELS - 1);
    end else begin
      pri_sat = req_i.priority_req;
    end
  end

  assign tag_in  = TAG_BITS'(req_i.tag);
  assign cmd.ins = do_ins;
  assign cmd.rem = do_rem;
  assign cmd.pri = pri_sat;

  assign keep_a[0]       = 1'b1;
  assign pri_a[0]        = pri_sat;
  assign tag_a[0]        = tag_in;
  assign pri_a[DEPTH+1]  = '0;
  assign tag_a[DEPTH+1]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sspq_cell #(
      .TAG_BITS (TAG_BITS),
      .INDEX    (i),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .count_i     (count_q),
      .new_tag_i   (tag_in),
      .left_keep_i (keep_a[i]),
      .left_pri_i  (pri_a[i]),
      .left_tag_i  (tag_a[i]),
      .right_pri_i (pri_a[i+2]),
      .right_tag_i (tag_a[i+2]),
      .keep_o      (keep_a[i+1]),
      .pri_o       (pri_a[i+1]),
      .tag_o       (tag_a[i+1])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    status_d = STAT_DONE;
    opri_d   = '0;
    otag_d   = '0;
    if (req_i.kind == KIND_REMOVE) begin
      if (empty) begin
        status_d = STAT_EMPTY;
      end else begin
        opri_d = pri_a[1];
        otag_d = TAG_W'(tag_a[1]);
      end
    end else if (full) begin
      status_d = STAT_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      outv_q   <= do_rem;
      opri_q   <= opri_d;
      otag_q   <= otag_d;
      occ_q    <= OCC_W'(count_d);
    end
  end

  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.out_valid    = outv_q;
  assign rsp_o.out_priority = opri_q;
  assign rsp_o.out_tag      = otag_q;
  assign rsp_o.occupancy    = occ_q;

endmodule

`default_nettype wire

[rtl/sspq_cell.sv]
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted row: holds, loads the new entry, or takes its
// left or right neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sspq_cell import sspq_pkg::*; #(
  parameter int TAG_BITS = 32,
  parameter int INDEX    = 0,
  parameter int CNT_W    = 5
) (
  input  wire logic                clk_i,
  input  wire cmd_t                cmd_i,
  input  wire logic [CNT_W-1:0]    count_i,
  input  wire logic [TAG_BITS-1:0] new_tag_i,
  input  wire logic                left_keep_i,
  input  wire logic [PRI_W-1:0]    left_pri_i,
  input  wire logic [TAG_BITS-1:0] left_tag_i,
  input  wire logic [PRI_W-1:0]    right_pri_i,
  input  wire logic [TAG_BITS-1:0] right_tag_i,
  output logic                     keep_o,
  output logic [PRI_W-1:0]         pri_o,
  output logic [TAG_BITS-1:0]      tag_o
);

  logic                occ;
  logic [PRI_W-1:0]    pri_q, pri_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;

  assign occ    = CNT_W'(INDEX) < count_i;
  // Stored entries of equal or lower number stay ahead of a new one
  assign keep_o = occ && (pri_q <= cmd_i.pri);

  always_comb begin
    pri_d = pri_q;
    tag_d = tag_q;
    if (cmd_i.ins && !keep_o) begin
      if (left_keep_i) begin
        pri_d = cmd_i.pri;
        tag_d = new_tag_i;
      end else begin
        pri_d = left_pri_i;
        tag_d = left_tag_i;
      end
    end else if (cmd_i.rem) begin
      pri_d = right_pri_i;
      tag_d = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pri_q <= pri_d;
    tag_q <= tag_d;
  end

  assign pri_o = pri_q;
  assign tag_o = tag_q;

endmodule

`default_nettype wire

[rtl/sspq_checker.sv]
// ----------------------------------------------------------------------------
// sspq_checker
// Port-level checks of the stable sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sspq_checker import sspq_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             req_valid_i,
  input wire logic             req_ready_i,
  input wire kind_e            req_kind_i,
  input wire logic             rsp_valid_i,
  input wire logic             rsp_ready_i,
  input wire status_e          rsp_status_i,
  input wire logic             rsp_out_valid_i,
  input wire logic [PRI_W-1:0] rsp_out_priority_i,
  input wire logic [TAG_W-1:0] rsp_out_tag_i,
  input wire logic [OCC_W-1:0] rsp_occupancy_i
);

  logic req_fire;
  assign req_fire = req_valid_i && req_ready_i;

  // Every accepted request shows its response on the next cycle
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> rsp_valid_i)
    else $error("no response after accepted request");

  // A stalled response holds its status, entry flag, tag and occupancy
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_out_valid_i) && $stable(rsp_out_tag_i)
      && $stable(rsp_occupancy_i)))
    else $error("stalled response changed");

  // A remove delivers an entry or reports empty, never full
  a_remove_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_kind_i == KIND_REMOVE) |=>
      ((rsp_out_valid_i && rsp_status_i == STAT_DONE) ||
       (!rsp_out_valid_i && rsp_status_i == STAT_EMPTY && rsp_out_tag_i == '0)))
    else $error("bad remove response");

  // An insert never delivers an entry
  a_insert_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_kind_i == KIND_INSERT) |=>
      (!rsp_out_valid_i && rsp_out_priority_i == '0 &&
       (rsp_status_i == STAT_DONE || rsp_status_i == STAT_FULL)))
    else $error("bad insert response");

endmodule

bind stable_sorted_priority_queue_unit sspq_checker u_sspq_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .req_kind_i         (req_i.kind),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_status_i       (rsp_o.status),
  .rsp_out_valid_i    (rsp_o.out_valid),
  .rsp_out_priority_i (rsp_o.out_priority),
  .rsp_out_tag_i      (rsp_o.out_tag),
  .rsp_occupancy_i    (rsp_o.occupancy)
);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stable sorted priority queue.
// ----------------------------------------------------------------------------
// Requests go in over the request channel and are predicted at acceptance by
// a sorted-array model of the queue. Each response is checked against the
// oldest prediction. Directed tests cover empty removes, field extremes and
// tie order. Random tests then fill and drain the queue in phases, so full
// rejects and empty removes recur. Both channels idle at random, except
// in one back-to-back stretch.

module tb_top;
  import sspq_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int PRI_LEVELS  = 16;
  localparam int KEPT_TAG    = 32;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [TAG_W-1:0] TAG_KEEP = {TAG_W{1'b1}} >> (TAG_W - KEPT_TAG);

  typedef struct {
    status_e          status;
    logic             out_valid;
    logic [PRI_W-1:0] out_priority;
    logic [TAG_W-1:0] out_tag;
    logic [OCC_W-1:0] occupancy;
  } queue_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic steady;          // no idling on either channel while set
  int   fail_count;
  int   cycle_count;

  // Model of the stored entries, head at index 0
  logic [PRI_W-1:0] held_pri [QDEPTH];
  logic [TAG_W-1:0] held_tag [QDEPTH];
  int unsigned      held_count;

  queue_rsp_t predicted_rsp_q[$];

  sspq_req_if req_if ();
  sspq_rsp_if rsp_if ();

  stable_sorted_priority_queue_unit #(
    .DEPTH          (QDEPTH),
    .PRIORITY_LEVELS(PRI_LEVELS),
    .TAG_BITS       (KEPT_TAG)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Work out the response of one request and update the stored entries
  function automatic queue_rsp_t apply_queue_request(kind_e k, logic [PRI_W-1:0] p_in,
                                                     logic [TAG_W-1:0] t_in);
    queue_rsp_t  r;
    int unsigned p;
    int unsigned pos;
    r.status       = STAT_DONE;
    r.out_valid    = 1'b0;
    r.out_priority = '0;
    r.out_tag      = '0;
    p = p_in;
    if (p >= PRI_LEVELS) p = PRI_LEVELS - 1;
    if (k == KIND_INSERT) begin
      if (held_count >= QDEPTH) begin
        r.status = STAT_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_pri[pos] <= p) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_pri[i] = held_pri[i-1];
          held_tag[i] = held_tag[i-1];
        end
        held_pri[pos] = p[PRI_W-1:0];
        held_tag[pos] = t_in & TAG_KEEP;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.out_valid    = 1'b1;
        r.out_priority = held_pri[0];
        r.out_tag      = held_tag[0];
        for (int i = 1; i < held_count; i++) begin
          held_pri[i-1] = held_pri[i];
          held_tag[i-1] = held_tag[i];
        end
        held_count--;
      end
    end
    r.occupancy = held_count[OCC_W-1:0];
    return r;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(kind_e k, logic [PRI_W-1:0] p, logic [TAG_W-1:0] t);
    while (!steady && $urandom_range(99) < 19) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.kind         <= k;
    req_if.priority_req <= p;
    req_if.tag          <= t;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted_rsp_q.push_back(apply_queue_request(k, p, t));
    @(negedge clk_i);
  endtask

  // Hold off new requests until every response is back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (predicted_rsp_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random(int insert_pct);
    logic [PRI_W-1:0] p;
    int               sel;
    sel = $urandom_range(9);
    if (sel < 4)      p = PRI_W'($urandom_range(3));   // dense ties
    else if (sel < 5) p = '0;
    else if (sel < 6) p = '1;
    else              p = PRI_W'($urandom_range(PRI_LEVELS - 1));
    if ($urandom_range(99) < insert_pct) send_request(KIND_INSERT, p, $urandom());
    else                                 send_request(KIND_REMOVE, p, $urandom());
  endtask

  task automatic test_remove_empty();
    send_request(KIND_REMOVE, 4'd9, 32'hDEAD_BEEF);
    wait_drained();
  endtask

  task automatic test_field_extremes();
    send_request(KIND_INSERT, 4'd15, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 4'd0, 32'h0000_0000);
    send_request(KIND_INSERT, 4'd8, 32'h5555_AAAA);
    repeat (3) send_request(KIND_REMOVE, '0, '0);
    wait_drained();
  endtask

  task automatic test_tie_order();
    send_request(KIND_INSERT, 4'd5, 32'd1);
    send_request(KIND_INSERT, 4'd5, 32'd2);
    send_request(KIND_INSERT, 4'd5, 32'd3);
    send_request(KIND_INSERT, 4'd4, 32'd9);
    send_request(KIND_INSERT, 4'd5, 32'd4);
    send_request(KIND_INSERT, 4'd6, 32'hAAAA_5555);
    repeat (7) send_request(KIND_REMOVE, 4'd15, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Run fill-heavy, drain-heavy and balanced phases in random order
  task automatic test_random_phases(int n_items);
    int sent;
    int phase_len;
    int insert_pct;
    sent = 0;
    while (sent < n_items) begin
      phase_len = $urandom_range(60, 15);
      case ($urandom_range(2))
        0: begin
          insert_pct = 85;
        end
        1: begin
          insert_pct = 15;
        end
        default: begin
          insert_pct = 50;
        end
      endcase
      for (int i = 0; i < phase_len && sent < n_items; i++) begin
        send_random(insert_pct);
        sent++;
      end
      if ($urandom_range(9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_back_to_back(int n_items);
    steady = 1'b1;
    for (int i = 0; i < n_items; i++) send_random((i / 40) % 2 == 0 ? 75 : 30);
    wait_drained();
    steady = 1'b0;
  endtask

  // Response side: random stalls, none while steady is set
  always @(negedge clk_i) begin
    rsp_if.ready <= rst_ni && (steady || $urandom_range(99) >= 19);
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (predicted_rsp_q.size() == 0) begin
        if (fail_count < 10) $display("unexpected response at cycle %0d", cycle_count);
        fail_count++;
      end else begin
        queue_rsp_t e;
        e = predicted_rsp_q.pop_front();
        if (rsp_if.status !== e.status || rsp_if.out_valid !== e.out_valid ||
            rsp_if.out_priority !== e.out_priority || rsp_if.out_tag !== e.out_tag ||
            rsp_if.occupancy !== e.occupancy) begin
          if (fail_count < 10) begin
            $display("cycle %0d exp st=%0d v=%0b pri=%0d tag=%h occ=%0d",
                     cycle_count, e.status, e.out_valid, e.out_priority, e.out_tag,
                     e.occupancy);
            $display("  got st=%0d v=%0b pri=%0d tag=%h occ=%0d",
                     rsp_if.status, rsp_if.out_valid, rsp_if.out_priority,
                     rsp_if.out_tag, rsp_if.occupancy);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    steady              = 1'b0;
    fail_count          = 0;
    cycle_count         = 0;
    held_count          = 0;
    req_if.valid        = 1'b0;
    req_if.kind         = KIND_INSERT;
    req_if.priority_req = '0;
    req_if.tag          = '0;
    rsp_if.ready        = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_remove_empty();
    test_field_extremes();
    test_tie_order();
    test_random_phases(1000);
    test_back_to_back(200);

    repeat (4) @(negedge clk_i);
    if (predicted_rsp_q.size() != 0) begin
      $display("%0d responses never arrived", predicted_rsp_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
